[rtl/core/tlca_pkg.sv]
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared constants and types for the tree LCA / distance query engine.
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int LEVELS      = 10;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int LEVEL_W     = $clog2(LEVELS);
   localparam int JADDR_W     = LEVEL_W + NODE_W;
   localparam int DEPTH_W     = 10;
   localparam int NEED_W      = DEPTH_W + 1;
   localparam int WEIGHT_W    = 32;
   localparam int DIST_W      = WEIGHT_W + 1;
   localparam int COUNT_W     = 11;
   localparam int CMD_W       = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - NODE_W - DIST_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LEVEL_W-1:0] TOP_LEVEL        = LEVEL_W'(LEVELS - 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT        = COUNT_W'(MAX_NODES);
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1024);

   // register index lives in paddr[2]
   localparam logic REG_NODE_COUNT = 1'b0;

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2
   } command_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } jump_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_Q_SWAP,
      ST_Q_LIFT,
      ST_Q_CLIMB,
      ST_Q_FIN,
      ST_Q_WP,
      ST_PUSH
   } state_type;

endpackage

[rtl/core/tree_lca_distance_query.sv]
// ----------------------------------------------------------------------------
// tree_lca_distance_query
// Binary-lifting lowest common ancestor and weighted distance engine.
// ----------------------------------------------------------------------------
// Load transactions (command 0) write a node's parent, depth and root weight in
// the accept cycle and return nothing; the next transaction is taken in the
// following cycle. A build transaction (command 1) fills ancestor levels 1 to
// LEVELS-1 for nodes 0 to min(node_count, MAX_NODES)-1 and returns one build
// result; each entry takes two dependent reads of the jump memory and a write.
// A query transaction (command 2) reads depths and weights, lifts the deeper
// node with one jump memory read per level, climbs both with one read per
// level, reads the final parent and then a weight, and loads the output
// register; the climb and parent read are skipped when the lifted node already
// meets the other. The result sits in an output register, so a new transaction
// is taken while it waits. Tables hold no reset value; nodes must be loaded
// before a build or query touches them. node_count must be written only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tree_lca_distance_query import tlca_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, low bit up: node_a[10], node_b[10], parent_node[10],
   // has_parent[1], node_depth[10], node_weight[32], zero pad[7]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: command[2]
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rsp_tdata, low bit up: ancestor[10], distance[33], zero pad[5]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: result_kind[1]
   output logic [0:0]             rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   // request fields
   logic [NODE_W-1:0]   req_node_a;
   logic [NODE_W-1:0]   req_node_b;
   logic [NODE_W-1:0]   req_parent_node;
   logic                req_has_parent;
   logic [DEPTH_W-1:0]  req_node_depth;
   logic [WEIGHT_W-1:0] req_node_weight;

   assign req_node_a      = req_tdata[9:0];
   assign req_node_b      = req_tdata[19:10];
   assign req_parent_node = req_tdata[29:20];
   assign req_has_parent  = req_tdata[30];
   assign req_node_depth  = req_tdata[40:31];
   assign req_node_weight = req_tdata[72:41];

   // memories
   jump_type            jump_mem   [LEVELS*MAX_NODES];
   logic [DEPTH_W-1:0]  depth_mem  [MAX_NODES];
   logic [WEIGHT_W-1:0] weight_mem [MAX_NODES];

   jump_type            jmp_rd0_ff, jmp_rd1_ff;
   logic [DEPTH_W-1:0]  dep_rd0_ff, dep_rd1_ff;
   logic [WEIGHT_W-1:0] wt_rd0_ff, wt_rd1_ff;

   logic                jmp_we;
   logic [JADDR_W-1:0]  jmp_wa;
   jump_type            jmp_wd;
   logic [JADDR_W-1:0]  jmp_ra0, jmp_ra1;
   logic                tbl_we;
   logic [NODE_W-1:0]   dep_ra0, dep_ra1;
   logic [NODE_W-1:0]   wt_ra0, wt_ra1;

   // control and datapath registers
   state_type           state_ff, state_in;
   logic [LEVEL_W-1:0]  k_ff, k_in;
   logic [NODE_W-1:0]   i_ff, i_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [NODE_W-1:0]   x_ff, x_in;
   logic [NODE_W-1:0]   y_ff, y_in;
   logic [DEPTH_W-1:0]  dy_ff, dy_in;
   logic [DIST_W-1:0]   wsum_ff, wsum_in;
   logic                half_valid_ff, half_valid_in;
   logic                res_kind_ff, res_kind_in;
   logic [NODE_W-1:0]   res_anc_ff, res_anc_in;
   logic [DIST_W-1:0]   res_dist_ff, res_dist_in;
   logic                rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                rsp_tuser_ff;
   logic [COUNT_W-1:0]  node_count_ff;
   logic                rsp_load;

   // per-level evaluation
   logic [NEED_W-1:0]   lift_need;
   logic                lift_take;
   logic [NODE_W-1:0]   x_lift;
   logic                climb_take;
   logic [NODE_W-1:0]   x_climb, y_climb;
   logic [NODE_W-1:0]   x_sw, y_sw;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NODE_COUNT)
                       ? {{(CSR_DATA_W-COUNT_W){1'b0}}, node_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_NODE_COUNT) begin
         node_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (jmp_we) begin
         jump_mem[jmp_wa] <= jmp_wd;
      end
      jmp_rd0_ff <= jump_mem[jmp_ra0];
      jmp_rd1_ff <= jump_mem[jmp_ra1];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         depth_mem[req_node_a] <= req_node_depth;
      end
      dep_rd0_ff <= depth_mem[dep_ra0];
      dep_rd1_ff <= depth_mem[dep_ra1];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         weight_mem[req_node_a] <= req_node_weight;
      end
      wt_rd0_ff <= weight_mem[wt_ra0];
      wt_rd1_ff <= weight_mem[wt_ra1];
   end

   // ---------------- level step logic ----------------
   always_comb begin
      lift_need  = {1'b0, dy_ff} + ({{(NEED_W-1){1'b0}}, 1'b1} << k_ff);
      lift_take  = ({1'b0, dep_rd0_ff} >= lift_need) && jmp_rd0_ff.valid;
      x_lift     = lift_take ? jmp_rd0_ff.node : x_ff;
      climb_take = jmp_rd0_ff.valid && jmp_rd1_ff.valid &&
                   (jmp_rd0_ff.node != jmp_rd1_ff.node);
      x_climb    = climb_take ? jmp_rd0_ff.node : x_ff;
      y_climb    = climb_take ? jmp_rd1_ff.node : y_ff;
      // deeper node goes to x
      if (dep_rd0_ff < dep_rd1_ff) begin
         x_sw = y_ff;
         y_sw = x_ff;
      end else begin
         x_sw = x_ff;
         y_sw = y_ff;
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      i_ff          <= i_in;
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dy_ff         <= dy_in;
      wsum_ff       <= wsum_in;
      half_valid_ff <= half_valid_in;
      res_kind_ff   <= res_kind_in;
      res_anc_ff    <= res_anc_in;
      res_dist_ff   <= res_dist_in;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dy_in         = dy_ff;
      wsum_in       = wsum_ff;
      half_valid_in = half_valid_ff;
      res_kind_in   = res_kind_ff;
      res_anc_in    = res_anc_ff;
      res_dist_in   = res_dist_ff;
      jmp_we        = 1'b0;
      jmp_wa        = {k_ff, i_ff};
      jmp_wd        = '0;
      jmp_ra0       = {k_ff, x_ff};
      jmp_ra1       = {k_ff, y_ff};
      tbl_we        = 1'b0;
      dep_ra0       = x_ff;
      dep_ra1       = y_ff;
      wt_ra0        = x_ff;
      wt_ra1        = y_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (command_type'(req_tuser))
                  CMD_LOAD: begin
                     jmp_we      = 1'b1;
                     jmp_wa      = {{LEVEL_W{1'b0}}, req_node_a};
                     jmp_wd.valid = req_has_parent;
                     jmp_wd.node  = req_has_parent ? req_parent_node : '0;
                     tbl_we      = 1'b1;
                  end
                  CMD_BUILD: begin
                     cnt_in      = (node_count_ff > MAX_COUNT) ? MAX_COUNT : node_count_ff;
                     k_in        = {{(LEVEL_W-1){1'b0}}, 1'b1};
                     i_in        = '0;
                     res_kind_in = KIND_BUILD;
                     res_anc_in  = '0;
                     res_dist_in = '0;
                     state_in    = (cnt_in == '0) ? ST_PUSH : ST_B_RD1;
                  end
                  CMD_QUERY: begin
                     x_in     = req_node_a;
                     y_in     = req_node_b;
                     dep_ra0  = req_node_a;
                     dep_ra1  = req_node_b;
                     wt_ra0   = req_node_a;
                     wt_ra1   = req_node_b;
                     state_in = ST_Q_SWAP;
                  end
                  default: ;
               endcase
            end
         end

         // build: read half jump, then the half jump of that node, then write
         ST_B_RD1: begin
            jmp_ra0  = {k_ff - 1'b1, i_ff};
            state_in = ST_B_RD2;
         end
         ST_B_RD2: begin
            half_valid_in = jmp_rd0_ff.valid;
            jmp_ra0       = {k_ff - 1'b1, jmp_rd0_ff.node};
            state_in      = ST_B_WR;
         end
         ST_B_WR: begin
            jmp_we = 1'b1;
            jmp_wa = {k_ff, i_ff};
            jmp_wd = half_valid_ff ? jmp_rd0_ff : '0;
            if ({1'b0, i_ff} == cnt_ff - 1'b1) begin
               i_in = '0;
               if (k_ff == TOP_LEVEL) begin
                  state_in = ST_PUSH;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_B_RD1;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_B_RD1;
            end
         end

         ST_Q_SWAP: begin
            wsum_in  = {1'b0, wt_rd0_ff} + {1'b0, wt_rd1_ff};
            x_in     = x_sw;
            y_in     = y_sw;
            dy_in    = (dep_rd0_ff < dep_rd1_ff) ? dep_rd0_ff : dep_rd1_ff;
            k_in     = TOP_LEVEL;
            jmp_ra0  = {TOP_LEVEL, x_sw};
            dep_ra0  = x_sw;
            state_in = ST_Q_LIFT;
         end

         // one level per cycle: next read address follows from this read
         ST_Q_LIFT: begin
            x_in = x_lift;
            if (k_ff == '0) begin
               if (x_lift == y_ff) begin
                  wt_ra0   = x_lift;
                  state_in = ST_Q_WP;
               end else begin
                  k_in     = TOP_LEVEL;
                  jmp_ra0  = {TOP_LEVEL, x_lift};
                  jmp_ra1  = {TOP_LEVEL, y_ff};
                  state_in = ST_Q_CLIMB;
               end
            end else begin
               k_in    = k_ff - 1'b1;
               jmp_ra0 = {k_ff - 1'b1, x_lift};
               dep_ra0 = x_lift;
            end
         end

         ST_Q_CLIMB: begin
            x_in = x_climb;
            y_in = y_climb;
            if (k_ff == '0) begin
               jmp_ra0  = {{LEVEL_W{1'b0}}, x_climb};
               state_in = ST_Q_FIN;
            end else begin
               k_in    = k_ff - 1'b1;
               jmp_ra0 = {k_ff - 1'b1, x_climb};
               jmp_ra1 = {k_ff - 1'b1, y_climb};
            end
         end

         // final parent step; with no parent the node reached is the answer
         ST_Q_FIN: begin
            x_in     = jmp_rd0_ff.valid ? jmp_rd0_ff.node : x_ff;
            wt_ra0   = x_in;
            state_in = ST_Q_WP;
         end

         ST_Q_WP: begin
            res_kind_in = KIND_QUERY;
            res_anc_in  = x_ff;
            res_dist_in = wsum_ff - {wt_rd0_ff, 1'b0};
            state_in    = ST_PUSH;
         end

         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, res_dist_ff, res_anc_ff};
         rsp_tuser_ff <= res_kind_ff;
      end
   end

endmodule

[rtl/core/tlca_checker.sv]
// ----------------------------------------------------------------------------
// tlca_checker
// Port-level checks for the tree LCA engine, bound to the top level.
// ----------------------------------------------------------------------------
module tlca_checker import tlca_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [CMD_W-1:0]       req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_build_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BUILD |-> rsp_tdata == '0)
      else $error("build result carries data");

   // a new result is pushed only from a busy cycle
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while idle");

   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_BUILD |=> !req_tready)
      else $error("build transaction did not occupy the engine");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind tree_lca_distance_query tlca_checker u_tlca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
